// ===== rtl/fdfp_pkg.sv =====
`default_nettype none

package fdfp_pkg;

  localparam int ByteW    = 8;
  localparam int ValueW   = 16;
  localparam int SlotW    = 10;
  localparam int CountW   = 7;
  localparam int SizeW    = 11;

  localparam logic [ByteW-1:0] CharStart = 8'h40;  // '@'
  localparam logic [ByteW-1:0] CharEnd   = 8'h23;  // '#'
  localparam logic [ByteW-1:0] CharSep   = 8'h7C;  // '|'
  localparam logic [ByteW-1:0] CharMinus = 8'h2D;  // '-'
  localparam logic [ByteW-1:0] CharZero  = 8'h30;  // '0'

  localparam logic [SizeW-1:0] ArraySizeReset = 11'd16;

  typedef enum logic {
    KIND_FIELD = 1'b0,
    KIND_END   = 1'b1
  } kind_t;

endpackage

`default_nettype wire

// ===== rtl/framed_decimal_field_parser.sv =====
`default_nettype none
// Pipeline: an accepted byte passes the input register, then the result register.
// Throughput: one byte per cycle; a blocked result stalls the input in the same cycle
//   once the input register holds a byte (an empty input register still takes one).
// Reset (rst, synchronous): leaves the frame, clears field and counters,
//   array_size returns to 16, both pipeline registers empty.
module framed_decimal_field_parser #(
  parameter int MAX_LEN = 128
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [fdfp_pkg::SizeW-1:0]       cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [fdfp_pkg::ByteW-1:0]       rx_byte,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  kind,
  output logic signed [fdfp_pkg::ValueW-1:0]    value,
  output logic [fdfp_pkg::SlotW-1:0]            slot,
  output logic                                  slot_valid,
  output logic [fdfp_pkg::CountW-1:0]           field_count
);

  localparam logic [fdfp_pkg::CountW-1:0] KeepLimit = fdfp_pkg::CountW'(MAX_LEN - 1);

  logic [fdfp_pkg::SizeW-1:0]  array_size;

  // input register
  logic                        byte_valid;
  logic [fdfp_pkg::ByteW-1:0]  byte_q;

  // parser state
  logic                        in_frame, in_frame_next;
  logic [fdfp_pkg::CountW-1:0] kept_length, kept_length_next;
  logic [fdfp_pkg::ValueW-1:0] accumulator, accumulator_next;
  logic                        negative, negative_next;
  logic                        field_start, field_start_next;
  logic [fdfp_pkg::SlotW-1:0]  next_slot, next_slot_next;
  logic [fdfp_pkg::CountW-1:0] separator_count, separator_count_next;

  logic                        res_valid;
  fdfp_pkg::kind_t             res_kind;
  logic [fdfp_pkg::ValueW-1:0] res_value;
  logic [fdfp_pkg::SlotW-1:0]  res_slot;
  logic                        res_slot_valid;
  logic [fdfp_pkg::CountW-1:0] res_count;

  logic                        advance;
  logic                        store_ok;
  logic [fdfp_pkg::ValueW-1:0] digit_sum;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = byte_valid && !advance;

  assign store_ok  = {1'b0, next_slot} < array_size;
  assign digit_sum = (accumulator << 3) + (accumulator << 1)
                   + {{(fdfp_pkg::ValueW-fdfp_pkg::ByteW){1'b0}}, byte_q}
                   - {{(fdfp_pkg::ValueW-fdfp_pkg::ByteW){1'b0}}, fdfp_pkg::CharZero};

  always_comb begin
    in_frame_next        = in_frame;
    kept_length_next     = kept_length;
    accumulator_next     = accumulator;
    negative_next        = negative;
    field_start_next     = field_start;
    next_slot_next       = next_slot;
    separator_count_next = separator_count;
    res_valid            = 1'b0;
    res_kind             = fdfp_pkg::KIND_FIELD;
    res_value            = '0;
    res_slot             = '0;
    res_slot_valid       = 1'b0;
    res_count            = '0;

    if (!in_frame) begin
      if (byte_q == fdfp_pkg::CharStart) begin
        in_frame_next = 1'b1;
      end
    end else if (byte_q == fdfp_pkg::CharEnd) begin
      res_valid            = 1'b1;
      res_kind             = fdfp_pkg::KIND_END;
      res_count            = separator_count;
      in_frame_next        = 1'b0;
      kept_length_next     = '0;
      accumulator_next     = '0;
      negative_next        = 1'b0;
      field_start_next     = 1'b1;
      next_slot_next       = fdfp_pkg::SlotW'(1);
      separator_count_next = '0;
    end else if (kept_length < KeepLimit) begin
      kept_length_next = kept_length + 1'b1;
      priority if (byte_q == fdfp_pkg::CharStart) begin
        accumulator_next = '0;
        negative_next    = 1'b0;
        field_start_next = 1'b1;
      end else if (byte_q == fdfp_pkg::CharSep) begin
        res_valid            = 1'b1;
        res_value            = negative ? (~accumulator + 1'b1) : accumulator;
        res_slot             = next_slot;
        res_slot_valid       = store_ok;
        if (store_ok) begin
          next_slot_next = next_slot + 1'b1;
        end
        separator_count_next = separator_count + 1'b1;
        accumulator_next     = '0;
        negative_next        = 1'b0;
        field_start_next     = 1'b1;
      end else if (field_start && byte_q == fdfp_pkg::CharMinus) begin
        negative_next    = 1'b1;
        field_start_next = 1'b0;
      end else begin
        field_start_next = 1'b0;
        accumulator_next = digit_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      array_size      <= fdfp_pkg::ArraySizeReset;
      byte_valid      <= 1'b0;
      out_valid       <= 1'b0;
      in_frame        <= 1'b0;
      kept_length     <= '0;
      accumulator     <= '0;
      negative        <= 1'b0;
      field_start     <= 1'b1;
      next_slot       <= fdfp_pkg::SlotW'(1);
      separator_count <= '0;
    end else begin
      if (cfg_write) begin
        array_size <= cfg_data;
      end
      if (!in_stall) begin
        byte_valid <= in_valid;
        byte_q     <= rx_byte;
      end
      if (advance) begin
        out_valid <= byte_valid && res_valid;
        if (byte_valid) begin
          kind            <= res_kind;
          value           <= res_value;
          slot            <= res_slot;
          slot_valid      <= res_slot_valid;
          field_count     <= res_count;
          in_frame        <= in_frame_next;
          kept_length     <= kept_length_next;
          accumulator     <= accumulator_next;
          negative        <= negative_next;
          field_start     <= field_start_next;
          next_slot       <= next_slot_next;
          separator_count <= separator_count_next;
        end
      end
    end
  end

  // slots only advance on separators
  a_slot_le_seps: assert property (@(posedge clk) disable iff (rst)
    {3'b000, separator_count} + 10'd1 >= next_slot)
    else $error("next_slot ran ahead of separator count");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> (kept_length == '0 && separator_count == '0 && next_slot == 10'd1))
    else $error("frame counters not cleared outside a frame");

  a_end_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == fdfp_pkg::KIND_END) |-> (value == '0 && slot == '0 && !slot_valid))
    else $error("frame end result carries field data");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (byte_valid && out_valid && out_stall))
    else $error("input stalled with room to advance");

  a_hold_blocked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(separator_count) && $stable(accumulator)))
    else $error("parser state moved while result blocked");

endmodule

`default_nettype wire

// ===== tb/framed_decimal_field_parser_tb.sv =====
module framed_decimal_field_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxLen      = 128;
  localparam int ByteTarget  = 1150;
  localparam int NumSettings = 8;
  localparam int CycleLimit  = 400_000;

  typedef struct packed {
    fdfp_pkg::kind_t                    kind;
    logic signed [fdfp_pkg::ValueW-1:0] value;
    logic [fdfp_pkg::SlotW-1:0]         slot;
    logic                               slot_valid;
    logic [fdfp_pkg::CountW-1:0]        field_count;
  } field_result_t;

  class field_parse_checker;
    field_result_t               expected_q[$];
    logic [fdfp_pkg::SizeW-1:0]  array_size;
    bit                          in_frame;
    int                          kept_len;
    logic [fdfp_pkg::ValueW-1:0] acc;
    bit                          negative;
    bit                          field_start;
    logic [fdfp_pkg::SlotW-1:0]  next_slot;
    logic [fdfp_pkg::CountW-1:0] sep_count;
    int                          mismatches;
    int                          checked;
    int                          frames_closed;

    function new();
      array_size    = fdfp_pkg::ArraySizeReset;
      mismatches    = 0;
      checked       = 0;
      frames_closed = 0;
      clear_frame();
    endfunction

    function void clear_field();
      acc         = '0;
      negative    = 1'b0;
      field_start = 1'b1;
    endfunction

    function void clear_frame();
      in_frame  = 1'b0;
      kept_len  = 0;
      next_slot = fdfp_pkg::SlotW'(1);
      sep_count = '0;
      clear_field();
    endfunction

    // Advance the parser by one accepted byte; queue the result it produces, if any.
    function void accept_byte(logic [fdfp_pkg::ByteW-1:0] b);
      field_result_t r;
      r = '0;
      if (!in_frame) begin
        in_frame = (b == fdfp_pkg::CharStart);
        return;
      end
      if (b == fdfp_pkg::CharEnd) begin
        r.kind        = fdfp_pkg::KIND_END;
        r.field_count = sep_count;
        expected_q.push_back(r);
        frames_closed++;
        clear_frame();
        return;
      end
      // frame is full: everything but the end marker is dropped
      if (kept_len >= MaxLen - 1) return;
      kept_len++;
      if (b == fdfp_pkg::CharStart) begin
        clear_field();
        return;
      end
      if (b == fdfp_pkg::CharSep) begin
        r.kind       = fdfp_pkg::KIND_FIELD;
        r.value      = negative ? -acc : acc;
        r.slot       = next_slot;
        r.slot_valid = ({1'b0, next_slot} < array_size);
        if (r.slot_valid) next_slot++;
        sep_count++;
        expected_q.push_back(r);
        clear_field();
        return;
      end
      if (field_start && b == fdfp_pkg::CharMinus) begin
        negative    = 1'b1;
        field_start = 1'b0;
        return;
      end
      // any other byte is a digit, even a minus sign past the field start
      field_start = 1'b0;
      acc = acc * 16'd10 + fdfp_pkg::ValueW'(b) - fdfp_pkg::ValueW'(fdfp_pkg::CharZero);
    endfunction

    function void note_mismatch(string what, int want, int got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check_result(field_result_t got);
      field_result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got kind %0d value %0d slot %0d",
                 $time, got.kind, got.value, got.slot);
        return;
      end
      want = expected_q.pop_front();
      if (got.kind != want.kind) note_mismatch("kind", want.kind, got.kind);
      if (got.value != want.value) note_mismatch("value", want.value, got.value);
      if (got.slot != want.slot) note_mismatch("slot", want.slot, got.slot);
      if (got.slot_valid != want.slot_valid)
        note_mismatch("slot_valid", want.slot_valid, got.slot_valid);
      if (got.field_count != want.field_count)
        note_mismatch("field_count", want.field_count, got.field_count);
    endfunction
  endclass

  logic                              clk         = 1'b0;
  logic                              rst         = 1'b1;
  logic                              cfg_write   = 1'b0;
  logic [fdfp_pkg::SizeW-1:0]        cfg_data    = '0;
  logic                              in_valid    = 1'b0;
  logic                              in_stall;
  logic [fdfp_pkg::ByteW-1:0]        rx_byte     = '0;
  logic                              out_valid;
  logic                              out_stall   = 1'b0;
  logic                              kind;
  logic signed [fdfp_pkg::ValueW-1:0] value;
  logic [fdfp_pkg::SlotW-1:0]        slot;
  logic                              slot_valid;
  logic [fdfp_pkg::CountW-1:0]       field_count;

  field_parse_checker sb = new();
  int cycle_count = 0;
  int stall_left  = 0;
  int free_left   = 0;
  int frame_bytes = 0;

  framed_decimal_field_parser #(
    .MAX_LEN(MaxLen)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .value      (value),
    .slot       (slot),
    .slot_valid (slot_valid),
    .field_count(field_count)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mostly decimal digits, now and then any byte at all
  function automatic logic [fdfp_pkg::ByteW-1:0] rand_digit();
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
    return fdfp_pkg::CharZero + 8'($urandom_range(0, 9));
  endfunction

  // Called at a falling edge; returns at a falling edge with in_valid possibly still high.
  task automatic send_bytes(input logic [fdfp_pkg::ByteW-1:0] data[$], input bit no_gaps);
    int gap;
    foreach (data[i]) begin
      rx_byte  <= data[i];
      in_valid <= 1'b1;
      do @(posedge clk); while (in_stall);
      sb.accept_byte(data[i]);
      @(negedge clk);
      gap = pick_gap();
      if (!no_gaps && gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Hold off input until every queued result is out and the pipeline is empty.
  task automatic drain_input();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_array_size(input logic [fdfp_pkg::SizeW-1:0] size);
    cfg_data  <= size;
    cfg_write <= 1'b1;
    @(posedge clk);
    sb.array_size = size;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  always @(negedge clk) begin : stall_driver
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left <= free_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 5) == 0) begin
        free_left <= $urandom_range(20, 120);
      end else begin
        stall_left <= pick_gap();
        free_left  <= $urandom_range(0, 4);
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    field_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.kind        = fdfp_pkg::kind_t'(kind);
      got.value       = value;
      got.slot        = slot;
      got.slot_valid  = slot_valid;
      got.field_count = field_count;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.expected_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [fdfp_pkg::SizeW-1:0] sizes[NumSettings];
    logic [fdfp_pkg::ByteW-1:0] q[$];
    string                      directed;
    int                         noise_len;
    int                         phase_start;
    int                         frame_no;
    int                         fields;
    int                         ndig;
    int                         r;
    bit                         long_frame;

    sizes    = '{fdfp_pkg::ArraySizeReset, 11'd1, 11'd0, 11'h7FF, 11'd1024, 11'd2,
                 11'd0, 11'd0};
    sizes[6] = 11'($urandom_range(1, 1024));
    sizes[7] = 11'($urandom_range(3, 40));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ignored bytes outside a frame, then sign, wrap, empty, lone minus,
    // mid-field minus, restart marker, byte extremes and a dropped trailing field
    directed = "z#|@-32768||-|1-2|5@7|";
    for (int i = 0; i < directed.len(); i++) q.push_back(directed[i]);
    q.push_back(8'h00);
    q.push_back(8'hFF);
    q.push_back(fdfp_pkg::CharSep);
    q.push_back("9");
    q.push_back(fdfp_pkg::CharEnd);
    send_bytes(q, 1'b0);

    for (int p = 0; p < NumSettings; p++) begin
      if (p > 0) begin
        drain_input();
        write_array_size(sizes[p]);
      end
      phase_start = frame_bytes;
      frame_no    = 0;
      while (frame_bytes - phase_start < ByteTarget / NumSettings) begin
        if ($urandom_range(0, 7) == 0) drain_input();
        q = {};
        repeat ($urandom_range(0, 3)) q.push_back(8'($urandom_range(0, 255)));
        noise_len = q.size();
        q.push_back(fdfp_pkg::CharStart);
        long_frame = (frame_no == 1) || ($urandom_range(0, 9) == 0);
        if (long_frame && $urandom_range(0, 1) == 0) begin
          // separator flood overruns the kept length
          repeat ($urandom_range(MaxLen, MaxLen + 8)) q.push_back(fdfp_pkg::CharSep);
        end else begin
          fields = long_frame ? 200 : $urandom_range(0, 8);
          for (int f = 0; f < fields && q.size() < noise_len + MaxLen + 20; f++) begin
            if ($urandom_range(0, 3) == 0) q.push_back(fdfp_pkg::CharMinus);
            ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
            repeat (ndig) q.push_back(rand_digit());
            r = $urandom_range(0, 19);
            if (r < 18) q.push_back(fdfp_pkg::CharSep);
            else if (r == 18) q.push_back(fdfp_pkg::CharStart);
          end
          if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) q.push_back(rand_digit());
        end
        q.push_back(fdfp_pkg::CharEnd);
        frame_bytes += q.size() - noise_len;
        send_bytes(q, $urandom_range(0, 3) == 0);
        frame_no++;
      end
    end

    drain_input();
    repeat (4) @(posedge clk);

    $display("Ran %0d framed bytes after the directed frame over %0d array_size settings",
             frame_bytes, NumSettings);
    $display("Checked %0d results from %0d frames, %0d mismatches",
             sb.checked, sb.frames_closed, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fdfp_pkg.sv
rtl/framed_decimal_field_parser.sv
tb/framed_decimal_field_parser_tb.sv
